@@ sv/lmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmsc_pkg
// Shared constants and types for the logistic-map stream cipher.
// ----------------------------------------------------------------------------
package lmsc_pkg;

    localparam int XW       = 32;
    localparam int MUW      = 32;
    localparam int MU_FRAC  = 30;
    localparam int MAX_LEN  = 255;

    localparam logic [31:0] MU_RESET   = 32'd4284186050;
    localparam logic [31:0] SEED_RESET = 32'd1288490189;
    localparam logic [7:0]  LEN_RESET  = 8'd16;

    localparam logic [1:0] REG_MU   = 2'd0;
    localparam logic [1:0] REG_SEED = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;
    localparam logic [1:0] REG_LEN  = 2'd3;

    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_NORM = 2'd1;

    // map unit request/response
    typedef struct packed {
        logic            start;
        logic [XW-1:0]   x;
        logic [MUW-1:0]  mu;
    } map_req_t;

    typedef struct packed {
        logic            done;
        logic [XW-1:0]   x_next;
    } map_rsp_t;

    typedef struct packed {
        logic            start;
        logic [39:0]     num;
        logic [XW-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [39:0]     quo;
    } div_rsp_t;

endpackage

@@ sv/logistic_map_stream_cipher_top.sv @@
// ----------------------------------------------------------------------------
// logistic_map_stream_cipher_top
// XORs each data item with a key byte from a logistic-map keystream.
// ----------------------------------------------------------------------------
// One item at a time. In mode 0 each item takes one map step on the shared
// multiplier; modes 2 and 3 go straight to the output. Mode 1 also runs the
// bit-serial divider, which is skipped when the maximum is zero; an item marked
// first adds a prescan of msg_len map steps. A result waits in an output register
// until taken, and the next item may be accepted and worked on meanwhile.
// Configuration is taken only while idle with no result waiting and no item offered.
module logistic_map_stream_cipher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  cipher_byte,
    output logic [7:0]  key_byte,
    output logic        zero_max
);

    typedef enum logic [6:0]
    {
        S_IDLE  = 7'b0000001,
        S_PRE   = 7'b0000010,
        S_PWAIT = 7'b0000100,
        S_TAKE  = 7'b0001000,
        S_STEP  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] mu_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  len_reg;
    logic [31:0] x_reg, min_reg, max_reg, px_reg;
    logic [7:0]  last_key_reg, cnt_reg, data_reg;
    logic [7:0]  key_reg;
    logic        zm_reg, div_pend_reg, step_pend_reg, step_go_reg;
    logic        out_valid_reg;
    logic [7:0]  cipher_out_reg, key_out_reg;
    logic        zm_out_reg;
    logic        out_load;
    logic [31:0] diff;
    logic [31:0] tmin, tmax;

    lmsc_pkg::map_req_t mreq;
    lmsc_pkg::map_rsp_t mrsp;
    lmsc_pkg::div_req_t dreq;
    lmsc_pkg::div_rsp_t drsp;

    lmsc_map u_map (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    lmsc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign cfg_ready = (state_reg == S_IDLE) && !out_valid_reg && !in_valid;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // hand the result over once the output register is free
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // take x into current min/max
    assign tmin = (x_reg < min_reg) ? x_reg : min_reg;
    assign tmax = (x_reg > max_reg) ? x_reg : max_reg;
    assign diff = x_reg - tmin;

    always_comb
    begin
        mreq.start = 1'b0;
        mreq.x     = x_reg;
        mreq.mu    = mu_reg;
        if (state_reg == S_PRE)
        begin
            mreq.start = 1'b1;
            mreq.x     = px_reg;
        end
        else if (state_reg == S_STEP && step_go_reg)
            mreq.start = 1'b1;
        dreq.start = (state_reg == S_TAKE) && (mode_reg == lmsc_pkg::MODE_NORM)
                     && (tmax != 32'd0);
        dreq.num   = {diff, 8'd0} - {8'd0, diff};
        dreq.den   = tmax;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    if (mode_reg == lmsc_pkg::MODE_LOW)
                        state_next = S_TAKE;
                    else if (mode_reg == lmsc_pkg::MODE_NORM)
                        state_next = (first && len_reg != 8'd0) ? S_PRE : S_TAKE;
                    else
                        state_next = S_OUT;
                end
            S_PRE:   state_next = S_PWAIT;
            S_PWAIT:
                if (mrsp.done)
                    state_next = (cnt_reg == 8'd1) ? S_TAKE : S_PRE;
            S_TAKE:  state_next = S_STEP;
            S_STEP:
                if (!step_go_reg && !step_pend_reg && !div_pend_reg)
                    state_next = S_OUT;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mu_reg         <= lmsc_pkg::MU_RESET;
            mode_reg       <= lmsc_pkg::MODE_LOW;
            len_reg        <= lmsc_pkg::LEN_RESET;
            x_reg          <= lmsc_pkg::SEED_RESET;
            min_reg        <= lmsc_pkg::SEED_RESET;
            max_reg        <= lmsc_pkg::SEED_RESET;
            px_reg         <= lmsc_pkg::SEED_RESET;
            last_key_reg   <= 8'd0;
            cnt_reg        <= 8'd0;
            data_reg       <= 8'd0;
            key_reg        <= 8'd0;
            zm_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            cipher_out_reg <= 8'd0;
            key_out_reg    <= 8'd0;
            zm_out_reg     <= 1'b0;
            div_pend_reg   <= 1'b0;
            step_pend_reg  <= 1'b0;
            step_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    lmsc_pkg::REG_MU:   mu_reg <= cfg_data;
                    lmsc_pkg::REG_SEED:
                    begin
                        x_reg    <= cfg_data;
                        min_reg  <= cfg_data;
                        max_reg  <= cfg_data;
                    end
                    lmsc_pkg::REG_MODE: mode_reg <= cfg_data[1:0];
                    lmsc_pkg::REG_LEN:  len_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        data_reg <= data_byte;
                        px_reg   <= x_reg;
                        cnt_reg  <= len_reg;
                        key_reg  <= last_key_reg;
                        zm_reg   <= 1'b0;
                    end
                end
                S_PRE:
                begin
                    min_reg <= (px_reg < min_reg) ? px_reg : min_reg;
                    max_reg <= (px_reg > max_reg) ? px_reg : max_reg;
                end
                S_PWAIT:
                    if (mrsp.done)
                    begin
                        px_reg  <= mrsp.x_next;
                        cnt_reg <= cnt_reg - 8'd1;
                    end
                S_TAKE:
                begin
                    min_reg       <= tmin;
                    max_reg       <= tmax;
                    step_go_reg   <= 1'b1;
                    step_pend_reg <= 1'b1;
                    if (mode_reg == lmsc_pkg::MODE_LOW)
                        key_reg <= x_reg[7:0];
                    else if (tmax == 32'd0)
                    begin
                        key_reg <= 8'd0;
                        zm_reg  <= 1'b1;
                    end
                    else
                        div_pend_reg <= 1'b1;
                end
                S_STEP:
                begin
                    step_go_reg <= 1'b0;
                    if (mrsp.done && !step_go_reg)
                    begin
                        x_reg         <= mrsp.x_next;
                        step_pend_reg <= 1'b0;
                    end
                    if (drsp.done)
                    begin
                        div_pend_reg <= 1'b0;
                        key_reg <= (drsp.quo > 40'd255) ? 8'd255 : drsp.quo[7:0];
                    end
                    if (state_next == S_OUT)
                        last_key_reg <= key_reg;
                end
                S_OUT:
                    if (out_load)
                    begin
                        cipher_out_reg <= data_reg ^ key_reg;
                        key_out_reg    <= key_reg;
                        zm_out_reg     <= zm_reg;
                    end
                default: ;
            endcase
        end
    end

    assign key_byte    = key_out_reg;
    assign cipher_byte = cipher_out_reg;
    assign zero_max    = zm_out_reg;

    // hold a waiting result unchanged until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
            (out_valid_reg && $stable(cipher_out_reg) && $stable(key_out_reg)
             && $stable(zm_out_reg)))
        else $error("waiting result changed");

    // zero_max only with key zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zm_out_reg) |-> (key_out_reg == 8'd0))
        else $error("zero_max with nonzero key");

    // a divider start must lead straight into the step phase
    assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |=> (state_reg == S_STEP))
        else $error("divider started outside step phase");

endmodule

@@ sv/lmsc_map.sv @@
// ----------------------------------------------------------------------------
// lmsc_map
// One logistic-map step over two passes of a shared 33x33 multiplier.
// ----------------------------------------------------------------------------
module lmsc_map
(
    input  logic               clk,
    input  logic               rst_n,
    input  lmsc_pkg::map_req_t req,
    output lmsc_pkg::map_rsp_t rsp
);

    typedef enum logic [2:0]
    {
        M_IDLE = 3'b001,
        M_MUL2 = 3'b010,
        M_DONE = 3'b100
    } mstate_t;

    mstate_t            state_reg, state_next;
    logic [31:0]        x_reg;
    logic [32:0]        a_reg;
    logic [32:0]        b_reg;
    logic [65:0]        prod;
    logic [32:0]        t_val;
    logic [35:0]        r_val;

    // shared multiplier
    assign prod  = {33'd0, a_reg} * {33'd0, b_reg};
    // t = floor(mu*x/2^32) fits in 32 bits (mu, x < 2^32)
    assign t_val = {1'b0, prod[63:32]};
    assign r_val = prod[65:30];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE: if (req.start) state_next = M_MUL2;
            M_MUL2: state_next = M_DONE;
            M_DONE: state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= M_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && req.start)
        begin
            x_reg <= req.x;
            a_reg <= {1'b0, req.mu};
            b_reg <= {1'b0, req.x};
        end
        else if (state_reg == M_MUL2)
        begin
            a_reg <= t_val;
            b_reg <= 33'h1_0000_0000 - {1'b0, x_reg};
        end
    end

    // result is valid during M_DONE, straight from the second product
    assign rsp.done   = (state_reg == M_DONE);
    assign rsp.x_next = (r_val[35:32] != 4'd0) ? 32'hFFFF_FFFF : r_val[31:0];

endmodule

@@ sv/lmsc_div.sv @@
// ----------------------------------------------------------------------------
// lmsc_div
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lmsc_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  lmsc_pkg::div_req_t req,
    output lmsc_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [39:0] q_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], q_reg[39]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd39;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.num;
            rem_reg <= 33'd0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[38:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[38:0], 1'b0};
            end
        end
    end

    assign rsp.done = busy_reg && (cnt_reg == 6'd0);
    assign rsp.quo  = {q_reg[38:0], ~trial[32]};

endmodule
